### rtl/rlle_pkg.sv
// Package: widths, operation codes, state encoding and RAM command type of the list engine.
`default_nettype none
package rlle_pkg;

    localparam int NODE_W    = 10;
    localparam int MAX_NODES = 1023;
    localparam int DEPTH     = MAX_NODES + 1;
    localparam int SUM_W     = 19;
    localparam int STEP_W    = $clog2(MAX_NODES + 2);
    localparam int OP_W      = 3;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [NODE_W-1:0] MAX_NODE_VAL = NODE_W'(MAX_NODES);
    localparam logic [STEP_W-1:0] MAX_STEPS    = STEP_W'(MAX_NODES + 1);

    localparam logic [OP_W-1:0] OP_INIT    = 3'd0;
    localparam logic [OP_W-1:0] OP_BEFORE  = 3'd1;
    localparam logic [OP_W-1:0] OP_AFTER   = 3'd2;
    localparam logic [OP_W-1:0] OP_SWAP    = 3'd3;
    localparam logic [OP_W-1:0] OP_REVERSE = 3'd4;
    localparam logic [OP_W-1:0] OP_REPORT  = 3'd5;

    // register index taken from paddr[2]
    localparam logic REG_LIST_SIZE = 1'b0;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_INIT = 10'b00_0000_0010,
        ST_GOTX = 10'b00_0000_0100,
        ST_RDY  = 10'b00_0000_1000,
        ST_GOTY = 10'b00_0001_0000,
        ST_E2   = 10'b00_0010_0000,
        ST_E3   = 10'b00_0100_0000,
        ST_E4   = 10'b00_1000_0000,
        ST_WALK = 10'b01_0000_0000,
        ST_DONE = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0] rd_addr;
        logic              nxt_we;
        logic [NODE_W-1:0] nxt_waddr;
        logic [NODE_W-1:0] nxt_wdata;
        logic              prv_we;
        logic [NODE_W-1:0] prv_waddr;
        logic [NODE_W-1:0] prv_wdata;
    } ram_cmd_t;

endpackage
`default_nettype wire

### rtl/rlle_if.sv
// Interfaces: operation request channel and result channel.
`default_nettype none
interface rlle_req_if;
    logic                       valid;
    logic                       ready;
    logic [rlle_pkg::OP_W-1:0]  op;
    logic [rlle_pkg::NODE_W-1:0] node_x;
    logic [rlle_pkg::NODE_W-1:0] node_y;
    modport source (output valid, op, node_x, node_y, input ready);
    modport sink (input valid, op, node_x, node_y, output ready);
endinterface

interface rlle_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [rlle_pkg::SUM_W-1:0]  odd_sum;
    modport source (output valid, status, odd_sum, input ready);
    modport sink (input valid, status, odd_sum, output ready);
endinterface
`default_nettype wire

### rtl/rlle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rlle_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/rlle_seq.sv
// Sequencer: runs each operation as reads and writes on the two link RAMs.
`default_nettype none
module rlle_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    rlle_req_if.sink                           req,
    rlle_rsp_if.source                         rsp,
    input  wire logic [rlle_pkg::NODE_W-1:0]   list_size,
    input  wire logic [rlle_pkg::NODE_W-1:0]   nxt_rdata,
    input  wire logic [rlle_pkg::NODE_W-1:0]   prv_rdata,
    output rlle_pkg::ram_cmd_t                 cmd
);

    rlle_pkg::state_t state_reg, state_next;
    logic [rlle_pkg::OP_W-1:0]   op_reg, op_next;
    logic [rlle_pkg::NODE_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [rlle_pkg::NODE_W-1:0] fx_reg, fx_next, bx_reg, bx_next;
    logic [rlle_pkg::NODE_W-1:0] pre_reg, pre_next, suc_reg, suc_next;
    logic [rlle_pkg::NODE_W-1:0] by_reg, by_next, fy_reg, fy_next;
    logic [rlle_pkg::NODE_W-1:0] live_reg, live_next, cnt_reg, cnt_next;
    logic [rlle_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic [rlle_pkg::SUM_W-1:0]  sum_reg, sum_next, osum_reg, osum_next;
    logic side_reg, side_next, rev_reg, rev_next, adj_reg, adj_next;
    logic par_reg, par_next, st_reg, st_next;
    logic ostat_reg, ostat_next, ovalid_reg, ovalid_next;

    logic [rlle_pkg::NODE_W-1:0] fwd_rd, bwd_rd;
    logic                        fw_en, bw_en;
    logic [rlle_pkg::NODE_W-1:0] fw_a, fw_d, bw_a, bw_d;
    logic                        accept, bad, is_edit;
    logic [rlle_pkg::NODE_W-1:0] n_sat;

    assign accept  = req.valid && req.ready;
    assign req.ready = (state_reg == rlle_pkg::ST_IDLE);
    assign fwd_rd  = side_reg ? prv_rdata : nxt_rdata;
    assign bwd_rd  = side_reg ? nxt_rdata : prv_rdata;
    assign is_edit = (req.op == rlle_pkg::OP_BEFORE) || (req.op == rlle_pkg::OP_AFTER)
                  || (req.op == rlle_pkg::OP_SWAP);
    assign bad = (req.node_x == '0) || (req.node_y == '0) || (req.node_x > live_reg)
              || (req.node_y > live_reg) || (req.node_x == req.node_y);
    assign n_sat = (list_size > rlle_pkg::MAX_NODE_VAL) ? rlle_pkg::MAX_NODE_VAL : list_size;

    assign rsp.valid   = ovalid_reg;
    assign rsp.status  = ostat_reg;
    assign rsp.odd_sum = osum_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg; x_next = x_reg; y_next = y_reg;
        fx_next = fx_reg; bx_next = bx_reg; pre_next = pre_reg; suc_next = suc_reg;
        by_next = by_reg; fy_next = fy_reg; live_next = live_reg; cnt_next = cnt_reg;
        steps_next = steps_reg; sum_next = sum_reg; side_next = side_reg;
        rev_next = rev_reg; adj_next = adj_reg; par_next = par_reg; st_next = st_reg;
        ostat_next = ostat_reg; osum_next = osum_reg; ovalid_next = ovalid_reg;
        fw_en = 1'b0; fw_a = '0; fw_d = '0;
        bw_en = 1'b0; bw_a = '0; bw_d = '0;
        cmd = '0;

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            rlle_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = req.op;
                    x_next    = req.node_x;
                    y_next    = req.node_y;
                    side_next = rev_reg ^ (req.op == rlle_pkg::OP_AFTER);
                    st_next   = 1'b0;
                    sum_next  = '0;
                    if (req.op == rlle_pkg::OP_INIT)
                    begin
                        live_next  = n_sat;
                        rev_next   = 1'b0;
                        cnt_next   = '0;
                        state_next = rlle_pkg::ST_INIT;
                    end
                    else if (is_edit)
                    begin
                        cmd.rd_addr = req.node_x;
                        if (bad)
                        begin
                            st_next    = 1'b1;
                            state_next = rlle_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = rlle_pkg::ST_GOTX;
                        end
                    end
                    else if (req.op == rlle_pkg::OP_REVERSE)
                    begin
                        rev_next   = ~rev_reg;
                        state_next = rlle_pkg::ST_DONE;
                    end
                    else if (req.op == rlle_pkg::OP_REPORT)
                    begin
                        cmd.rd_addr = '0;
                        steps_next  = '0;
                        par_next    = 1'b0;
                        state_next  = (live_reg == '0) ? rlle_pkg::ST_DONE : rlle_pkg::ST_WALK;
                    end
                    else
                    begin
                        st_next    = 1'b1;
                        state_next = rlle_pkg::ST_DONE;
                    end
                end
            end
            rlle_pkg::ST_INIT:
            begin
                // fill one entry of both tables per cycle
                cmd.nxt_we    = 1'b1;
                cmd.nxt_waddr = cnt_reg;
                cmd.nxt_wdata = (cnt_reg == live_reg) ? '0 : cnt_reg + 1'b1;
                cmd.prv_we    = 1'b1;
                cmd.prv_waddr = cnt_reg;
                cmd.prv_wdata = (cnt_reg == '0) ? live_reg : cnt_reg - 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == live_reg)
                begin
                    state_next = rlle_pkg::ST_DONE;
                end
            end
            rlle_pkg::ST_GOTX:
            begin
                fx_next = fwd_rd;
                bx_next = bwd_rd;
                if (op_reg == rlle_pkg::OP_SWAP)
                begin
                    cmd.rd_addr = y_reg;
                    state_next  = rlle_pkg::ST_GOTY;
                end
                else
                begin
                    // unlink x
                    fw_en = 1'b1; fw_a = bwd_rd; fw_d = fwd_rd;
                    bw_en = 1'b1; bw_a = fwd_rd; bw_d = bwd_rd;
                    state_next = rlle_pkg::ST_RDY;
                end
            end
            rlle_pkg::ST_RDY:
            begin
                cmd.rd_addr = y_reg;
                state_next  = rlle_pkg::ST_GOTY;
            end
            rlle_pkg::ST_GOTY:
            begin
                state_next = rlle_pkg::ST_E2;
                if (op_reg != rlle_pkg::OP_SWAP)
                begin
                    fw_en = 1'b1; fw_a = x_reg; fw_d = y_reg;
                    bw_en = 1'b1; bw_a = x_reg; bw_d = bwd_rd;
                    pre_next = bwd_rd;
                end
                else if ((fx_reg == y_reg) || (bx_reg == y_reg))
                begin
                    adj_next = 1'b1;
                    if (bx_reg == y_reg)
                    begin
                        // y leads: rename so that x comes first
                        x_next = y_reg; y_next = x_reg;
                        pre_next = bwd_rd; suc_next = fx_reg;
                        fw_en = 1'b1; fw_a = bwd_rd; fw_d = x_reg;
                        bw_en = 1'b1; bw_a = x_reg; bw_d = bwd_rd;
                    end
                    else
                    begin
                        pre_next = bx_reg; suc_next = fwd_rd;
                        fw_en = 1'b1; fw_a = bx_reg; fw_d = y_reg;
                        bw_en = 1'b1; bw_a = y_reg; bw_d = bx_reg;
                    end
                end
                else
                begin
                    adj_next = 1'b0;
                    pre_next = bx_reg; suc_next = fx_reg;
                    by_next  = bwd_rd; fy_next  = fwd_rd;
                    fw_en = 1'b1; fw_a = bx_reg; fw_d = y_reg;
                    bw_en = 1'b1; bw_a = fx_reg; bw_d = y_reg;
                end
            end
            rlle_pkg::ST_E2:
            begin
                if (op_reg != rlle_pkg::OP_SWAP)
                begin
                    fw_en = 1'b1; fw_a = pre_reg; fw_d = x_reg;
                    bw_en = 1'b1; bw_a = y_reg; bw_d = x_reg;
                    state_next = rlle_pkg::ST_DONE;
                end
                else if (adj_reg)
                begin
                    fw_en = 1'b1; fw_a = x_reg; fw_d = suc_reg;
                    bw_en = 1'b1; bw_a = suc_reg; bw_d = x_reg;
                    state_next = rlle_pkg::ST_E3;
                end
                else
                begin
                    fw_en = 1'b1; fw_a = x_reg; fw_d = fy_reg;
                    bw_en = 1'b1; bw_a = x_reg; bw_d = by_reg;
                    state_next = rlle_pkg::ST_E3;
                end
            end
            rlle_pkg::ST_E3:
            begin
                if (adj_reg)
                begin
                    fw_en = 1'b1; fw_a = y_reg; fw_d = x_reg;
                    bw_en = 1'b1; bw_a = x_reg; bw_d = y_reg;
                    state_next = rlle_pkg::ST_DONE;
                end
                else
                begin
                    fw_en = 1'b1; fw_a = by_reg; fw_d = x_reg;
                    bw_en = 1'b1; bw_a = fy_reg; bw_d = x_reg;
                    state_next = rlle_pkg::ST_E4;
                end
            end
            rlle_pkg::ST_E4:
            begin
                fw_en = 1'b1; fw_a = y_reg; fw_d = suc_reg;
                bw_en = 1'b1; bw_a = y_reg; bw_d = pre_reg;
                state_next = rlle_pkg::ST_DONE;
            end
            rlle_pkg::ST_WALK:
            begin
                // one node per cycle: the read data is the next address
                if ((fwd_rd == '0) || (steps_reg > rlle_pkg::MAX_STEPS - 1'b1))
                begin
                    state_next = rlle_pkg::ST_DONE;
                end
                else
                begin
                    if (!par_reg)
                    begin
                        sum_next = sum_reg + rlle_pkg::SUM_W'(fwd_rd);
                    end
                    par_next    = ~par_reg;
                    steps_next  = steps_reg + 1'b1;
                    cmd.rd_addr = fwd_rd;
                end
            end
            rlle_pkg::ST_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = st_reg;
                    osum_next   = sum_reg;
                    state_next  = rlle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rlle_pkg::ST_IDLE;
            end
        endcase

        if (fw_en || bw_en)
        begin
            cmd.nxt_we    = side_reg ? bw_en : fw_en;
            cmd.nxt_waddr = side_reg ? bw_a : fw_a;
            cmd.nxt_wdata = side_reg ? bw_d : fw_d;
            cmd.prv_we    = side_reg ? fw_en : bw_en;
            cmd.prv_waddr = side_reg ? fw_a : bw_a;
            cmd.prv_wdata = side_reg ? fw_d : bw_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlle_pkg::ST_IDLE;
            op_reg <= '0; x_reg <= '0; y_reg <= '0;
            fx_reg <= '0; bx_reg <= '0; pre_reg <= '0; suc_reg <= '0;
            by_reg <= '0; fy_reg <= '0; live_reg <= '0; cnt_reg <= '0;
            steps_reg <= '0; sum_reg <= '0; side_reg <= 1'b0; rev_reg <= 1'b0;
            adj_reg <= 1'b0; par_reg <= 1'b0; st_reg <= 1'b0;
            ostat_reg <= 1'b0; osum_reg <= '0; ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next; x_reg <= x_next; y_reg <= y_next;
            fx_reg <= fx_next; bx_reg <= bx_next; pre_reg <= pre_next; suc_reg <= suc_next;
            by_reg <= by_next; fy_reg <= fy_next; live_reg <= live_next; cnt_reg <= cnt_next;
            steps_reg <= steps_next; sum_reg <= sum_next; side_reg <= side_next;
            rev_reg <= rev_next; adj_reg <= adj_next; par_reg <= par_next; st_reg <= st_next;
            ostat_reg <= ostat_next; osum_reg <= osum_next; ovalid_reg <= ovalid_next;
        end
    end

    a_init_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlle_pkg::ST_INIT) |-> (cmd.nxt_we && cmd.prv_we))
        else $error("init must write both link tables");

    a_bad_edit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_edit && bad) |=> (state_reg == rlle_pkg::ST_DONE) && st_reg)
        else $error("flagged edit must finish with bad status");

    a_reverse: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.op == rlle_pkg::OP_REVERSE)) |=> (rev_reg != $past(rev_reg)))
        else $error("reverse must toggle direction");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlle_pkg::ST_WALK) |-> (steps_reg <= rlle_pkg::MAX_STEPS))
        else $error("report walk past its bound");

endmodule
`default_nettype wire

### rtl/reversible_linked_list_engine.sv
// Top level: reversible linked list engine with APB register port and link RAMs.
//
// Usage: the list is held as next/prev link tables over nodes 1..n with
// sentinel 0. Each request beat on req (op, node_x, node_y) yields exactly
// one result beat on rsp (status, odd_sum). Issue init before any edit.
// Register list_size (byte address 0) sets n for the next init; writes
// through the APB port complete in the access cycle (pready is tied high).
// Steps per item, accept to result ready:
//   init          writes entries 0..n (one table entry per cycle)
//   move before/after, swap: read x and y, then rewrite links; reverse / flagged op: no RAM access
//   report        one link read per node
// The link RAMs have registered read data, and each table takes
// one write per cycle. One item is worked at a time.
// A finished result waits in the output register; a new request is taken
// while it waits, and a second result holds until rsp.ready frees the slot.
// Reset clears control state, the direction and the node count; list_size
// returns to 1. The link tables are not cleared: init writes them.
`default_nettype none
module reversible_linked_list_engine (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    rlle_req_if.sink                             req,
    rlle_rsp_if.source                           rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rlle_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [rlle_pkg::PDATA_W-1:0]    pwdata,
    output logic [rlle_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    logic [rlle_pkg::NODE_W-1:0] list_size_reg;
    logic [rlle_pkg::NODE_W-1:0] nxt_rdata, prv_rdata;
    rlle_pkg::ram_cmd_t          cmd;
    logic                        apb_wr;

    // register write lands in the access cycle
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_size_reg <= rlle_pkg::NODE_W'(1);
        end
        else if (apb_wr && (paddr[2] == rlle_pkg::REG_LIST_SIZE))
        begin
            list_size_reg <= pwdata[rlle_pkg::NODE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == rlle_pkg::REG_LIST_SIZE)
        begin
            prdata = {{(rlle_pkg::PDATA_W-rlle_pkg::NODE_W){1'b0}}, list_size_reg};
        end
    end

    // link tables: both read at the same node each cycle
    rlle_ram #(.WIDTH(rlle_pkg::NODE_W), .DEPTH(rlle_pkg::DEPTH)) u_next_ram (
        .clk   (clk),
        .we    (cmd.nxt_we),
        .waddr (cmd.nxt_waddr),
        .wdata (cmd.nxt_wdata),
        .raddr (cmd.rd_addr),
        .rdata (nxt_rdata)
    );

    rlle_ram #(.WIDTH(rlle_pkg::NODE_W), .DEPTH(rlle_pkg::DEPTH)) u_prev_ram (
        .clk   (clk),
        .we    (cmd.prv_we),
        .waddr (cmd.prv_waddr),
        .wdata (cmd.prv_wdata),
        .raddr (cmd.rd_addr),
        .rdata (prv_rdata)
    );

    // operation sequencer and result register
    rlle_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .list_size (list_size_reg),
        .nxt_rdata (nxt_rdata),
        .prv_rdata (prv_rdata),
        .cmd       (cmd)
    );

endmodule
`default_nettype wire
